FILE: rtl/core/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the countdown / stopwatch timer
// Operation codes, register map, configuration and result structs, and the
// decimal digit helpers used by the update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    // time limits
    localparam logic [6:0] MaxMin = 7'd99;
    localparam logic [5:0] MaxSec = 6'd59;

    // register reset values
    localparam logic [31:0] DefAlarmTimeout   = 32'd120000;
    localparam logic [31:0] DefAdjustInterval = 32'd500;

    // configuration port geometry
    localparam int AddrW = 4;
    localparam int DataW = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] RegInitMin    = 2'd0;
    localparam logic [1:0] RegInitSec    = 2'd1;
    localparam logic [1:0] RegAlarmTmo   = 2'd2;
    localparam logic [1:0] RegAdjustIntv = 2'd3;

    // operation codes
    localparam logic [3:0] OpTick      = 4'd0;
    localparam logic [3:0] OpTimeout   = 4'd1;
    localparam logic [3:0] OpStart     = 4'd2;
    localparam logic [3:0] OpRestart   = 4'd3;
    localparam logic [3:0] OpStop      = 4'd4;
    localparam logic [3:0] OpStopwatch = 4'd5;
    localparam logic [3:0] OpReset     = 4'd6;
    localparam logic [3:0] OpClrAlarm  = 4'd7;
    localparam logic [3:0] OpAdjust    = 4'd8;
    localparam logic [3:0] OpSaveDef   = 4'd9;
    localparam logic [3:0] OpRestDef   = 4'd10;
    localparam logic [3:0] OpInit      = 4'd11;

    // adjust target and direction
    localparam logic FieldMin = 1'b0;
    localparam logic DirInc   = 1'b0;

    typedef struct packed {
        logic [6:0]  init_min;
        logic [5:0]  init_sec;
        logic [31:0] alarm_limit;
        logic [31:0] adjust_interval;
    } cfg_t;

    typedef struct packed {
        logic [3:0] func;
        logic [31:0] time_ms;
        logic        which_field;
        logic        direction;
    } item_t;

    typedef struct packed {
        logic [3:0] sec_ones;
        logic [2:0] sec_tens;
        logic [3:0] min_ones;
        logic [3:0] min_tens;
        logic       alarm_active;
        logic       enabled_flag;
        logic       counting_up_flag;
        logic       counting_down_flag;
    } res_t;

    // tens digit of a value 0..99 by threshold compares
    function automatic logic [3:0] dec_tens(input logic [6:0] value);
        logic [3:0] t;
        t = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (value >= 7'(10 * k))
            begin
                t = 4'(k);
            end
        end
        return t;
    endfunction

    // ones digit given the tens digit
    function automatic logic [3:0] dec_ones(input logic [6:0] value, input logic [3:0] tens);
        logic [6:0] r;
        r = value - ({3'b000, tens} * 7'd10);
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cst_in_if.sv
// ----------------------------------------------------------------------------
// cst_in_if: input item channel
// Valid/ready channel carrying one timer operation and its timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [31:0] time_ms;
    logic        which_field;
    logic        direction;

    modport source (output valid, func, time_ms, which_field, direction, input ready);
    modport sink (input valid, func, time_ms, which_field, direction, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cst_out_if.sv
// ----------------------------------------------------------------------------
// cst_out_if: result item channel
// Valid/ready channel carrying the displayed digits and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [3:0] min_tens;
    logic       alarm_active;
    logic       enabled_flag;
    logic       counting_up_flag;
    logic       counting_down_flag;

    modport source (output valid, sec_ones, sec_tens, min_ones, min_tens, alarm_active,
                    enabled_flag, counting_up_flag, counting_down_flag, input ready);
    modport sink (input valid, sec_ones, sec_tens, min_ones, min_tens, alarm_active,
                  enabled_flag, counting_up_flag, counting_down_flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cst_regs.sv
// ----------------------------------------------------------------------------
// cst_regs: configuration register file
// APB-style write/read of the four timer registers, with range clamping on
// the initial minutes and seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cst_pkg::AddrW-1:0]  paddr,
    input  wire logic [cst_pkg::DataW-1:0]  pwdata,
    output logic      [cst_pkg::DataW-1:0]  prdata,
    output logic                            pready,
    output cst_pkg::cfg_t                   cfg
);

    logic [6:0]     init_min_reg;
    logic [5:0]     init_sec_reg;
    logic [31:0]    alarm_tmo_reg;
    logic [31:0]    adjust_intv_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;
    logic [6:0]     wr_min_next;
    logic [5:0]     wr_sec_next;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // clamp out-of-range time values
    assign wr_min_next = (pwdata[6:0] > cst_pkg::MaxMin) ? cst_pkg::MaxMin : pwdata[6:0];
    assign wr_sec_next = (pwdata[5:0] > cst_pkg::MaxSec) ? cst_pkg::MaxSec : pwdata[5:0];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_min_reg    <= '0;
            init_sec_reg    <= '0;
            alarm_tmo_reg   <= cst_pkg::DefAlarmTimeout;
            adjust_intv_reg <= cst_pkg::DefAdjustInterval;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                cst_pkg::RegInitMin:    init_min_reg    <= wr_min_next;
                cst_pkg::RegInitSec:    init_sec_reg    <= wr_sec_next;
                cst_pkg::RegAlarmTmo:   alarm_tmo_reg   <= pwdata;
                cst_pkg::RegAdjustIntv: adjust_intv_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            cst_pkg::RegInitMin:    prdata = {25'd0, init_min_reg};
            cst_pkg::RegInitSec:    prdata = {26'd0, init_sec_reg};
            cst_pkg::RegAlarmTmo:   prdata = alarm_tmo_reg;
            cst_pkg::RegAdjustIntv: prdata = adjust_intv_reg;
            default:                prdata = '0;
        endcase
    end

    assign cfg.init_min        = init_min_reg;
    assign cfg.init_sec        = init_sec_reg;
    assign cfg.alarm_limit     = alarm_tmo_reg;
    assign cfg.adjust_interval = adjust_intv_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cst_engine.sv
// ----------------------------------------------------------------------------
// cst_engine: timer state and single-pass update
// Holds time, default time, mode flags and timestamps; applies one operation
// per step and presents the resulting digits and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  cst_pkg::item_t      item,
    input  cst_pkg::cfg_t       cfg,
    output cst_pkg::res_t       res
);

    logic [5:0]  sec_reg, sec_next;
    logic [6:0]  min_reg, min_next;
    logic [5:0]  sv_sec_reg, sv_sec_next;
    logic [6:0]  sv_min_reg, sv_min_next;
    logic        up_reg, up_next;
    logic        dn_reg, dn_next;
    logic        alarm_reg, alarm_next;
    logic        en_reg, en_next;
    logic [31:0] alarm_stamp_reg, alarm_stamp_next;
    logic [31:0] adj_stamp_reg, adj_stamp_next;

    logic [31:0] alarm_age;
    logic [31:0] adj_age;
    logic        counting;
    logic        do_sec_up;
    logic        do_sec_dn;
    logic [3:0]  min_t;
    logic [3:0]  sec_t;

    function automatic logic [6:0] min_inc(input logic [6:0] m);
        return (m >= cst_pkg::MaxMin) ? 7'd0 : m + 7'd1;
    endfunction

    function automatic logic [6:0] min_dec(input logic [6:0] m);
        return (m == 7'd0) ? cst_pkg::MaxMin : m - 7'd1;
    endfunction

    assign alarm_age = item.time_ms - alarm_stamp_reg;
    assign adj_age   = item.time_ms - adj_stamp_reg;
    assign counting  = !alarm_reg && en_reg;

    // next state for the operation in hand
    always_comb
    begin
        sec_next         = sec_reg;
        min_next         = min_reg;
        sv_sec_next      = sv_sec_reg;
        sv_min_next      = sv_min_reg;
        up_next          = up_reg;
        dn_next          = dn_reg;
        alarm_next       = alarm_reg;
        en_next          = en_reg;
        alarm_stamp_next = alarm_stamp_reg;
        adj_stamp_next   = adj_stamp_reg;
        do_sec_up        = 1'b0;
        do_sec_dn        = 1'b0;

        case (item.func)
            cst_pkg::OpTick:
            begin
                if (up_reg && counting)
                begin
                    do_sec_up = 1'b1;
                end
                else if (dn_reg && counting)
                begin
                    do_sec_dn = 1'b1;
                end
            end
            cst_pkg::OpTimeout:
            begin
                if (alarm_reg && (alarm_age >= cfg.alarm_limit))
                begin
                    alarm_next = 1'b0;
                    en_next    = 1'b0;
                end
            end
            cst_pkg::OpStart:
            begin
                if (!dn_reg)
                begin
                    sv_sec_next = sec_reg;
                    sv_min_next = min_reg;
                    dn_next     = 1'b1;
                end
            end
            cst_pkg::OpRestart: dn_next = 1'b1;
            cst_pkg::OpStop:    dn_next = 1'b0;
            cst_pkg::OpStopwatch:
            begin
                if (!up_reg)
                begin
                    sv_sec_next = sec_reg;
                    sv_min_next = min_reg;
                    sec_next    = '0;
                    min_next    = '0;
                    up_next     = 1'b1;
                end
            end
            cst_pkg::OpReset:
            begin
                if (up_reg || dn_reg)
                begin
                    alarm_next = 1'b0;
                    dn_next    = 1'b0;
                    up_next    = 1'b0;
                    sec_next   = sv_sec_reg;
                    min_next   = sv_min_reg;
                    en_next    = 1'b1;
                end
            end
            cst_pkg::OpClrAlarm:
            begin
                if (alarm_reg)
                begin
                    alarm_next = 1'b0;
                    dn_next    = 1'b0;
                end
            end
            cst_pkg::OpAdjust:
            begin
                if (adj_age > cfg.adjust_interval)
                begin
                    if (item.which_field == cst_pkg::FieldMin)
                    begin
                        min_next = (item.direction == cst_pkg::DirInc) ?
                                   min_inc(min_reg) : min_dec(min_reg);
                    end
                    else if (item.direction == cst_pkg::DirInc)
                    begin
                        do_sec_up = 1'b1;
                    end
                    else
                    begin
                        do_sec_dn = 1'b1;
                    end
                    adj_stamp_next = item.time_ms;
                end
            end
            cst_pkg::OpSaveDef:
            begin
                sv_sec_next = sec_reg;
                sv_min_next = min_reg;
            end
            cst_pkg::OpRestDef:
            begin
                sec_next = sv_sec_reg;
                min_next = sv_min_reg;
            end
            cst_pkg::OpInit:
            begin
                sv_sec_next = cfg.init_sec;
                sv_min_next = cfg.init_min;
                sec_next    = cfg.init_sec;
                min_next    = cfg.init_min;
            end
            default: ;
        endcase

        // seconds step up, carrying into minutes only as a stopwatch
        if (do_sec_up)
        begin
            if (sec_reg >= cst_pkg::MaxSec)
            begin
                sec_next = '0;
                if (up_reg)
                begin
                    min_next = min_inc(min_reg);
                end
            end
            else
            begin
                sec_next = sec_reg + 6'd1;
            end
        end

        // seconds step down, alarm on reaching zero while counting down
        if (do_sec_dn)
        begin
            if (sec_reg == 6'd0)
            begin
                sec_next = cst_pkg::MaxSec;
                if (dn_reg)
                begin
                    min_next = min_dec(min_reg);
                end
            end
            else
            begin
                sec_next = sec_reg - 6'd1;
                if ((sec_reg == 6'd1) && (min_reg == 7'd0) && dn_reg)
                begin
                    alarm_next       = 1'b1;
                    alarm_stamp_next = item.time_ms;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg         <= '0;
            min_reg         <= '0;
            sv_sec_reg      <= '0;
            sv_min_reg      <= '0;
            up_reg          <= 1'b0;
            dn_reg          <= 1'b0;
            alarm_reg       <= 1'b0;
            en_reg          <= 1'b1;
            alarm_stamp_reg <= '0;
            adj_stamp_reg   <= '0;
        end
        else if (step)
        begin
            sec_reg         <= sec_next;
            min_reg         <= min_next;
            sv_sec_reg      <= sv_sec_next;
            sv_min_reg      <= sv_min_next;
            up_reg          <= up_next;
            dn_reg          <= dn_next;
            alarm_reg       <= alarm_next;
            en_reg          <= en_next;
            alarm_stamp_reg <= alarm_stamp_next;
            adj_stamp_reg   <= adj_stamp_next;
        end
    end

    // decimal digits of the updated time
    assign sec_t = cst_pkg::dec_tens({1'b0, sec_next});
    assign min_t = cst_pkg::dec_tens(min_next);

    assign res.sec_ones           = cst_pkg::dec_ones({1'b0, sec_next}, sec_t);
    assign res.sec_tens           = sec_t[2:0];
    assign res.min_ones           = cst_pkg::dec_ones(min_next, min_t);
    assign res.min_tens           = min_t;
    assign res.alarm_active       = alarm_next;
    assign res.enabled_flag       = en_next;
    assign res.counting_up_flag   = up_next;
    assign res.counting_down_flag = dn_next;

endmodule

`default_nettype wire

FILE: rtl/core/countdown_stopwatch_timer.sv
// ----------------------------------------------------------------------------
// countdown_stopwatch_timer: mm:ss countdown timer and stopwatch
// Pipeline: an accepted item waits in the input register; its state update
//   is then written into the result register and presented on out_ch.
// Throughput: 1 item per cycle while out_ch takes results; else the input stalls.
// Reset: rst_n async active low; time and default 00:00, modes and alarm
//   off, counting enabled, registers at their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_stopwatch_timer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    cst_in_if.sink                          in_ch,
    cst_out_if.source                       out_ch,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cst_pkg::AddrW-1:0]  paddr,
    input  wire logic [cst_pkg::DataW-1:0]  pwdata,
    output logic      [cst_pkg::DataW-1:0]  prdata,
    output logic                            pready
);

    cst_pkg::cfg_t  cfg;
    cst_pkg::item_t item_reg;
    cst_pkg::res_t  res;
    cst_pkg::res_t  res_reg;
    logic           in_vld_reg, in_vld_next;
    logic           out_vld_reg, out_vld_next;
    logic           in_fire;
    logic           advance;

    // configuration registers
    cst_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline handshake
    assign advance      = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready  = !in_vld_reg || advance;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_vld_next  = in_fire ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.func        <= in_ch.func;
            item_reg.time_ms     <= in_ch.time_ms;
            item_reg.which_field <= in_ch.which_field;
            item_reg.direction   <= in_ch.direction;
        end
    end

    // state update
    cst_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid              = out_vld_reg;
    assign out_ch.sec_ones           = res_reg.sec_ones;
    assign out_ch.sec_tens           = res_reg.sec_tens;
    assign out_ch.min_ones           = res_reg.min_ones;
    assign out_ch.min_tens           = res_reg.min_tens;
    assign out_ch.alarm_active       = res_reg.alarm_active;
    assign out_ch.enabled_flag       = res_reg.enabled_flag;
    assign out_ch.counting_up_flag   = res_reg.counting_up_flag;
    assign out_ch.counting_down_flag = res_reg.counting_down_flag;

    // an item moved to the result stage is presented next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result not valid after advance");

    // an empty input stage always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> in_ch.ready)
        else $error("input stalled while empty");

    // digits stay decimal
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (res_reg.sec_ones <= 4'd9) && (res_reg.sec_tens <= 3'd5) &&
                        (res_reg.min_ones <= 4'd9) && (res_reg.min_tens <= 4'd9))
        else $error("digit out of range");

endmodule

`default_nettype wire
